/* src/ksp_pkg.sv */
package ksp_pkg;

  localparam int VERTICES_DEF  = 64;
  localparam int MAX_EDGES_DEF = 256;

  localparam int FW  = 6;   // vertex field width
  localparam int WW  = 32;  // weight width, Q16.16
  localparam int CSW = 38;  // total cost width

  typedef struct packed {
    logic load;
    logic run_init;
    logic clr_step;
    logic scan_init;
    logic scan_step;
    logic walk_start_a;
    logic walk_start_b;
    logic walk_rd;
    logic walk_adv;
    logic hit_a;
    logic hit_b;
    logic join1;
    logic join2;
    logic emit;
    logic final_push;
    logic done;
  } ksp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic best_ok;
    logic root_hit;
    logic same_root;
    logic tec_full;
    logic out_free;
    logic pend_ok;
  } ksp_sts_t;

endpackage

/* src/ksp_ctrl.sv */
module ksp_ctrl import ksp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_edge,
  output logic      in_stall,
  input  ksp_sts_t  sts,
  output ksp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_NEXT  = 14'b00000000000100,
    S_SCAN  = 14'b00000000001000,
    S_DRAIN = 14'b00000000010000,
    S_PICK  = 14'b00000000100000,
    S_WA_RD = 14'b00000001000000,
    S_WA_CK = 14'b00000010000000,
    S_WB_RD = 14'b00000100000000,
    S_WB_CK = 14'b00001000000000,
    S_JOIN1 = 14'b00010000000000,
    S_JOIN2 = 14'b00100000000000,
    S_EMIT  = 14'b01000000000000,
    S_FINAL = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_edge) begin
            cmd.run_init = 1'b1;
            state_nxt    = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (sts.tec_full) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_DRAIN;
        else cmd.scan_step = 1'b1;
      end
      S_DRAIN: state_nxt = S_PICK;
      S_PICK: begin
        if (sts.best_ok) begin
          cmd.walk_start_a = 1'b1;
          state_nxt        = S_WA_RD;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_WA_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WA_CK;
      end
      S_WA_CK: begin
        if (sts.root_hit) begin
          cmd.hit_a        = 1'b1;
          cmd.walk_start_b = 1'b1;
          state_nxt        = S_WB_RD;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_WA_RD;
        end
      end
      S_WB_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WB_CK;
      end
      S_WB_CK: begin
        if (sts.root_hit) begin
          if (sts.same_root) begin
            state_nxt = S_NEXT;
          end else begin
            cmd.hit_b = 1'b1;
            state_nxt = S_JOIN1;
          end
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_WB_RD;
        end
      end
      S_JOIN1: begin
        cmd.join1 = 1'b1;
        state_nxt = S_JOIN2;
      end
      S_JOIN2: begin
        cmd.join2 = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.pend_ok || sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.final_push = 1'b1;
          cmd.done       = 1'b1;
          state_nxt      = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule

/* src/ksp_dp.sv */
module ksp_dp import ksp_pkg::*; #(
  parameter int VERTICES  = VERTICES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [FW-1:0]         in_from_vertex,
  input  logic [FW-1:0]         in_to_vertex,
  input  logic signed [WW-1:0]  in_edge_weight,
  input  ksp_cmd_t              cmd,
  output ksp_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FW-1:0]         out_tree_from,
  output logic [FW-1:0]         out_tree_to,
  output logic signed [WW-1:0]  out_tree_weight,
  output logic signed [CSW-1:0] out_total_cost,
  output logic                  out_has_edge,
  output logic                  out_overflow,
  output logic                  out_last_result
);

  localparam int VW = $clog2(VERTICES);
  localparam int SW = $clog2(VERTICES + 1);
  localparam int PW = SW + VW;
  localparam int EW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);

  // edge store
  logic [FW-1:0]        mem_f [MAX_EDGES];
  logic [FW-1:0]        mem_t [MAX_EDGES];
  logic signed [WW-1:0] mem_w [MAX_EDGES];
  // forest: {size, parent} per vertex
  logic [PW-1:0]        mem_p [VERTICES];

  logic [CW-1:0]        cnt_r;
  logic                 ovf_r;
  logic                 in_ok, full;

  logic [VW-1:0]        clr_idx_r;
  logic [CW-1:0]        scan_idx_r;
  logic                 rv_r;
  logic [EW-1:0]        ri_r;
  logic [FW-1:0]        rf_r, rt_r;
  logic signed [WW-1:0] rw_r;

  logic                 prev_ok_r, best_ok_r;
  logic signed [WW-1:0] prev_w_r, best_w_r;
  logic [EW-1:0]        prev_i_r, best_i_r;
  logic [FW-1:0]        best_f_r, best_t_r;
  logic                 gt_prev, lt_best;

  logic [VW-1:0]        walk_r, ra_r, rb_r;
  logic [PW-1:0]        pq_r;
  logic [SW-1:0]        sa_r, sb_r, size_sum;
  logic                 a_small;
  logic                 fw_en;
  logic [VW-1:0]        fw_addr;
  logic [PW-1:0]        fw_data;

  logic signed [CSW-1:0] cost_r, cost_add;
  logic [VW-1:0]         tec_r;
  logic                  pend_ok_r;
  logic [FW-1:0]         pend_f_r, pend_t_r;
  logic signed [WW-1:0]  pend_w_r;
  logic signed [CSW-1:0] pend_cost_r;
  logic                  out_valid_r, out_free, push;

  assign in_ok = (32'(in_from_vertex) < VERTICES) && (32'(in_to_vertex) < VERTICES);
  assign full  = (cnt_r == CW'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (cmd.load && in_ok && !full) begin
      mem_f[cnt_r[EW-1:0]] <= in_from_vertex;
      mem_t[cnt_r[EW-1:0]] <= in_to_vertex;
      mem_w[cnt_r[EW-1:0]] <= in_edge_weight;
    end
    if (cmd.scan_step) begin
      rf_r <= mem_f[scan_idx_r[EW-1:0]];
      rt_r <= mem_t[scan_idx_r[EW-1:0]];
      rw_r <= mem_w[scan_idx_r[EW-1:0]];
    end
    ri_r <= scan_idx_r[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.done) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.load && in_ok) begin
      if (!full) cnt_r <= cnt_r + 1'b1;
      else ovf_r <= 1'b1;
    end
  end

  // next edge in (weight, load order) after the previous pick
  assign gt_prev = !prev_ok_r || (rw_r > prev_w_r) ||
                   ((rw_r == prev_w_r) && (ri_r > prev_i_r));
  assign lt_best = !best_ok_r || (rw_r < best_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r       <= 1'b0;
      prev_ok_r  <= 1'b0;
      best_ok_r  <= 1'b0;
      scan_idx_r <= '0;
      clr_idx_r  <= '0;
    end else begin
      rv_r <= cmd.scan_step;
      if (cmd.run_init) begin
        prev_ok_r <= 1'b0;
        best_ok_r <= 1'b0;
        clr_idx_r <= '0;
      end else if (cmd.scan_init) begin
        scan_idx_r <= '0;
        best_ok_r  <= 1'b0;
        if (best_ok_r) begin
          prev_ok_r <= 1'b1;
          prev_w_r  <= best_w_r;
          prev_i_r  <= best_i_r;
        end
      end else begin
        if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
        if (cmd.scan_step) scan_idx_r <= scan_idx_r + 1'b1;
        if (rv_r && gt_prev && lt_best) begin
          best_ok_r <= 1'b1;
          best_w_r  <= rw_r;
          best_i_r  <= ri_r;
          best_f_r  <= rf_r;
          best_t_r  <= rt_r;
        end
      end
    end
  end

  // root walk over the forest
  always_ff @(posedge clk) begin
    if (cmd.walk_start_a) walk_r <= VW'(best_f_r);
    else if (cmd.walk_start_b) walk_r <= VW'(best_t_r);
    else if (cmd.walk_adv) walk_r <= pq_r[VW-1:0];
    if (cmd.walk_rd) pq_r <= mem_p[walk_r];
    if (cmd.hit_a) begin
      ra_r <= walk_r;
      sa_r <= pq_r[PW-1:VW];
    end
    if (cmd.hit_b) begin
      rb_r <= walk_r;
      sb_r <= pq_r[PW-1:VW];
    end
  end

  assign a_small  = (sa_r < sb_r);
  assign size_sum = sa_r + sb_r;

  always_comb begin
    fw_en   = 1'b0;
    fw_addr = clr_idx_r;
    fw_data = {SW'(1), clr_idx_r};
    if (cmd.clr_step) begin
      fw_en = 1'b1;
    end else if (cmd.join1) begin
      fw_en   = 1'b1;
      fw_addr = a_small ? ra_r : rb_r;
      fw_data = a_small ? {sa_r, rb_r} : {sb_r, ra_r};
    end else if (cmd.join2) begin
      fw_en   = 1'b1;
      fw_addr = a_small ? rb_r : ra_r;
      fw_data = {size_sum, a_small ? rb_r : ra_r};
    end
  end

  always_ff @(posedge clk) begin
    if (fw_en) mem_p[fw_addr] <= fw_data;
  end

  // hold one accepted edge back so the final one can carry the last flag
  assign cost_add = cost_r + CSW'(best_w_r);
  assign out_free = !out_valid_r || !out_stall;
  assign push     = (cmd.emit && pend_ok_r) || cmd.final_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_ok_r   <= 1'b0;
      tec_r       <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.run_init) begin
        pend_ok_r <= 1'b0;
        tec_r     <= '0;
        cost_r    <= '0;
      end else if (cmd.emit) begin
        pend_ok_r   <= 1'b1;
        pend_f_r    <= best_f_r;
        pend_t_r    <= best_t_r;
        pend_w_r    <= best_w_r;
        pend_cost_r <= cost_add;
        cost_r      <= cost_add;
        tec_r       <= tec_r + 1'b1;
      end
      if (push) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_overflow    <= ovf_r;
      out_last_result <= cmd.final_push;
      out_has_edge    <= pend_ok_r;
      out_tree_from   <= pend_ok_r ? pend_f_r : '0;
      out_tree_to     <= pend_ok_r ? pend_t_r : '0;
      out_tree_weight <= pend_ok_r ? pend_w_r : '0;
      out_total_cost  <= pend_ok_r ? pend_cost_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.clr_last  = (clr_idx_r == VW'(VERTICES - 1));
  assign sts.scan_done = (scan_idx_r == cnt_r);
  assign sts.best_ok   = best_ok_r;
  assign sts.root_hit  = (pq_r[VW-1:0] == walk_r);
  assign sts.same_root = (walk_r == ra_r);
  assign sts.tec_full  = (tec_r == VW'(VERTICES - 1));
  assign sts.out_free  = out_free;
  assign sts.pend_ok   = pend_ok_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_EDGES)) else $error("edge count beyond capacity");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free) else $error("result overwritten while stalled");
  a_tec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.tec_full) else $error("tree edge count overrun");
  a_no_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !cmd.load && !cmd.scan_step) else $error("commands collide");
`endif

endmodule

/* src/kruskal_spanning_tree.sv */
// Load: one edge transaction per cycle, stored in the edge memory.
// Run after the last edge: clear the forest, then for each visited edge scan
// the store to pick it, walk from both its ends to their roots (a read and a
// check per vertex on the path), and, if the roots differ, join and emit.
// Results come one per accepted edge; new edges are stalled until the run ends.
// Reset (rst_n low, synchronous) clears the controller, counts and output valid.
module kruskal_spanning_tree import ksp_pkg::*; #(
  parameter int VERTICES  = VERTICES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FW-1:0]         in_from_vertex,
  input  logic [FW-1:0]         in_to_vertex,
  input  logic signed [WW-1:0]  in_edge_weight,
  input  logic                  in_last_edge,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FW-1:0]         out_tree_from,
  output logic [FW-1:0]         out_tree_to,
  output logic signed [WW-1:0]  out_tree_weight,
  output logic signed [CSW-1:0] out_total_cost,
  output logic                  out_has_edge,
  output logic                  out_overflow,
  output logic                  out_last_result
);

  ksp_cmd_t cmd;
  ksp_sts_t sts;

  ksp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_edge (in_last_edge),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  ksp_dp #(
    .VERTICES  (VERTICES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_from_vertex  (in_from_vertex),
    .in_to_vertex    (in_to_vertex),
    .in_edge_weight  (in_edge_weight),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tree_from   (out_tree_from),
    .out_tree_to     (out_tree_to),
    .out_tree_weight (out_tree_weight),
    .out_total_cost  (out_total_cost),
    .out_has_edge    (out_has_edge),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result)
  );

endmodule
